// File: rtl/jpeg_end_and_mp4_start_locator_defines.svh
// ----------------------------------------------------------------------------
// JPEG end and MP4 start locator: assertion macros
// Shared macros for the concurrent checks of the locator.
// ----------------------------------------------------------------------------
`ifndef JPEG_END_AND_MP4_START_LOCATOR_DEFINES_SVH
`define JPEG_END_AND_MP4_START_LOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JEMSL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JEMSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/jemsl_pkg.sv
// ----------------------------------------------------------------------------
// jemsl_pkg
// Types, codes and constants shared by the locator modules.
// ----------------------------------------------------------------------------
package jemsl_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int RSP_OFFSET_BITS     = 32;
   localparam int BOX_LEAD_BYTES      = 8;
   localparam int MIN_SEG_LEN         = 2;

   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_RST0   = 8'hD0;
   localparam logic [7:0] MARK_RST7   = 8'hD7;
   localparam logic [7:0] STUFF_ZERO  = 8'h00;

   localparam logic [2:0] MATCH_FULL = 3'd4;

   typedef enum logic [3:0] {
      PH_PREFIX,
      PH_MARKER,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SKIP,
      PH_SCAN,
      PH_SCAN_FF,
      PH_SEARCH,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_JPEG_END,
      KIND_MP4_START,
      KIND_JPEG_FAIL,
      KIND_MP4_MISSING
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [RSP_OFFSET_BITS-1:0] offset;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } parse_result_type;

   typedef struct packed {
      logic      step;
      phase_type phase;
   } parse_status_type;

   // Letters of the box type "ftyp", first letter at index zero.
   function automatic logic [7:0] tag_byte(input logic [1:0] idx);
      logic [7:0] letter;
      case (idx)
         2'd0:    letter = 8'h66;
         2'd1:    letter = 8'h74;
         2'd2:    letter = 8'h79;
         2'd3:    letter = 8'h70;
         default: letter = 8'h66;
      endcase
      return letter;
   endfunction

endpackage

// File: rtl/jemsl_in_reg.sv
// ----------------------------------------------------------------------------
// jemsl_in_reg
// Input register: holds one request beat until the parser takes it.
// ----------------------------------------------------------------------------
module jemsl_in_reg
   import jemsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       take,
   output logic       item_valid,
   output logic       item_type,
   output logic [7:0] item_byte
);

   logic       valid_ff, valid_in;
   logic       type_ff;
   logic [7:0] byte_ff;
   logic       accept;

   // The register may refill in the same cycle it is drained.
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_tuser;
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_type  = type_ff;
   assign item_byte  = byte_ff;

endmodule

// File: rtl/jemsl_parser.sv
// ----------------------------------------------------------------------------
// jemsl_parser
// Marker walker and "ftyp" search: one byte per step, at most one result.
// ----------------------------------------------------------------------------
module jemsl_parser
   import jemsl_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             item_type,
   input  logic [7:0]       item_byte,
   output parse_result_type result,
   output parse_status_type status
);

   localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
   localparam logic [OFFSET_BITS-1:0] BOX_LEAD = OFFSET_BITS'(BOX_LEAD_BYTES);
   localparam logic [15:0]            SEG_MIN  = 16'(MIN_SEG_LEN);

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [15:0]            skip_ff, skip_in;
   logic [7:0]             len_hi_ff, len_hi_in;
   logic [2:0]             match_ff, match_in;

   logic [OFFSET_BITS-1:0] cur_off;
   logic [OFFSET_BITS-1:0] box_off;
   logic [15:0]            seg_len;
   logic [15:0]            skip_dec;
   logic [2:0]             match_next;
   phase_type              marker_phase;
   logic                   scan_ignore;

   assign cur_off  = OFFSET_BITS'(off_ff + OFF_ONE);
   assign box_off  = (cur_off >= BOX_LEAD) ? OFFSET_BITS'(cur_off - BOX_LEAD) : '0;
   assign seg_len  = {len_hi_ff, item_byte};
   assign skip_dec = (skip_ff != 16'd0) ? 16'(skip_ff - 16'd1) : skip_ff;

   assign match_next = (item_byte == tag_byte(match_ff[1:0])) ? 3'(match_ff + 3'd1) :
                       ((item_byte == tag_byte(2'd0)) ? 3'd1 : 3'd0);

   assign scan_ignore = (item_byte inside {STUFF_ZERO, MARK_PREFIX, [MARK_RST0:MARK_RST7]});

   // Where a marker code other than the image end leads.
   always_comb begin
      if (item_byte == MARK_SOI) begin
         marker_phase = PH_PREFIX;
      end else if (item_byte == MARK_SOS) begin
         marker_phase = PH_SCAN;
      end else begin
         marker_phase = PH_LEN_HI;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      off_in             = off_ff;
      skip_in            = skip_ff;
      len_hi_in          = len_hi_ff;
      match_in           = match_ff;
      result.valid       = 1'b0;
      result.beat.kind   = KIND_JPEG_END;
      result.beat.offset = '0;

      if (step) begin
         if (item_type == REQ_END) begin
            if (phase_ff == PH_SEARCH) begin
               result.valid     = 1'b1;
               result.beat.kind = KIND_MP4_MISSING;
            end else if (phase_ff != PH_DONE) begin
               result.valid     = 1'b1;
               result.beat.kind = KIND_JPEG_FAIL;
            end
            phase_in  = PH_PREFIX;
            off_in    = '0;
            skip_in   = '0;
            len_hi_in = '0;
            match_in  = '0;
         end else begin
            off_in = cur_off;
            case (phase_ff)
               PH_PREFIX: begin
                  if (item_byte == MARK_PREFIX) begin
                     phase_in = PH_MARKER;
                  end else begin
                     phase_in         = PH_SEARCH;
                     match_in         = '0;
                     result.valid     = 1'b1;
                     result.beat.kind = KIND_JPEG_FAIL;
                  end
               end
               PH_MARKER, PH_SCAN_FF: begin
                  if (phase_ff == PH_SCAN_FF && scan_ignore) begin
                     phase_in = PH_SCAN;
                  end else if (item_byte == MARK_EOI) begin
                     phase_in           = PH_SEARCH;
                     match_in           = '0;
                     result.valid       = 1'b1;
                     result.beat.kind   = KIND_JPEG_END;
                     result.beat.offset = RSP_OFFSET_BITS'(cur_off);
                  end else begin
                     phase_in = marker_phase;
                  end
               end
               PH_LEN_HI: begin
                  len_hi_in = item_byte;
                  phase_in  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  if (seg_len < SEG_MIN) begin
                     phase_in         = PH_SEARCH;
                     match_in         = '0;
                     result.valid     = 1'b1;
                     result.beat.kind = KIND_JPEG_FAIL;
                  end else if (seg_len == SEG_MIN) begin
                     phase_in = PH_PREFIX;
                  end else begin
                     skip_in  = 16'(seg_len - SEG_MIN);
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_in = skip_dec;
                  if (skip_dec == 16'd0) begin
                     phase_in = PH_PREFIX;
                  end
               end
               PH_SCAN: begin
                  if (item_byte == MARK_PREFIX) begin
                     phase_in = PH_SCAN_FF;
                  end
               end
               PH_SEARCH: begin
                  match_in = match_next;
                  if (match_next >= MATCH_FULL) begin
                     match_in           = '0;
                     phase_in           = PH_DONE;
                     result.valid       = 1'b1;
                     result.beat.kind   = KIND_MP4_START;
                     result.beat.offset = RSP_OFFSET_BITS'(box_off);
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         off_ff    <= '0;
         skip_ff   <= '0;
         len_hi_ff <= '0;
         match_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         off_ff    <= off_in;
         skip_ff   <= skip_in;
         len_hi_ff <= len_hi_in;
         match_ff  <= match_in;
      end
   end

   assign status.step  = step;
   assign status.phase = phase_ff;

endmodule

// File: rtl/jemsl_rsp_buf.sv
// ----------------------------------------------------------------------------
// jemsl_rsp_buf
// Two-entry result register: full rate while streaming, absorbs one stall.
// ----------------------------------------------------------------------------
module jemsl_rsp_buf
   import jemsl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsp_beat_type               push_beat,
   output logic                       space,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_OFFSET_BITS-1:0] rsp_tdata,
   output logic [1:0]                 rsp_tuser
);

   rsp_beat_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = (count_ff != 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = 2'(count_ff + 2'd1);
      end else if (pop && !push) begin
         count_in = 2'(count_ff - 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

   assign rsp_tdata = entry_ff[rd_ptr_ff].offset;
   assign rsp_tuser = entry_ff[rd_ptr_ff].kind;

endmodule

// File: rtl/jpeg_end_and_mp4_start_locator.sv
// ----------------------------------------------------------------------------
// jpeg_end_and_mp4_start_locator
// Finds where a JPEG image ends and an appended MP4 box starts in a file.
// ----------------------------------------------------------------------------
// The file enters on the req_ channel one byte per beat: req_tdata holds the
// byte and req_tuser marks the end of the stream, which also clears all
// parsing state so the next file can follow at once. Each beat gives zero or
// one result on the rsp_ channel: rsp_tuser holds the kind (image end, MP4
// start, parse failure, MP4 start not found) and rsp_tdata the byte offset.
// A beat waits in the input register until the parser steps on it, which
// needs room in the result register behind rsp_; the step writes its result
// there. One beat is taken every cycle while the result register has room;
// the marker walker and the four-letter search are a single state update.
// The result register holds two beats, so while the receiver drops
// rsp_tready the block still takes a beat until both are full, and then
// req_tready falls until the receiver drains one. Synchronous reset empties
// both registers, returns the parser to expecting a marker prefix and zeroes
// the byte counter.
// ----------------------------------------------------------------------------
`include "jpeg_end_and_mp4_start_locator_defines.svh"

module jpeg_end_and_mp4_start_locator
   import jemsl_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
   input  logic                       clock,
   input  logic                       reset,
   // Request channel.
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [7:0] data_byte
   input  logic                       req_tuser,  // [0] req_type
   // Result channel.
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_OFFSET_BITS-1:0] rsp_tdata,  // [31:0] offset
   output logic [1:0]                 rsp_tuser   // [1:0] found_kind
);

   logic             item_valid;
   logic             item_type;
   logic [7:0]       item_byte;
   logic             buf_space;
   logic             step;
   parse_result_type result;
   parse_status_type status;

   // Terms of the checks below.
   logic             step_room;
   logic             end_step;
   logic             prefix_phase;
   logic             zero_kind_push;
   logic             zero_off;

   // The parser only advances when the result register can take its beat.
   assign step = item_valid && buf_space;

   jemsl_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (step),
      .item_valid (item_valid),
      .item_type  (item_type),
      .item_byte  (item_byte)
   );

   jemsl_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item_type (item_type),
      .item_byte (item_byte),
      .result    (result),
      .status    (status)
   );

   jemsl_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result.valid),
      .push_beat  (result.beat),
      .space      (buf_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign step_room      = status.step && buf_space;
   assign end_step       = status.step && (item_type == REQ_END);
   assign prefix_phase   = (status.phase == PH_PREFIX);
   assign zero_kind_push = result.valid && (result.beat.kind == KIND_JPEG_FAIL ||
                                            result.beat.kind == KIND_MP4_MISSING);
   assign zero_off       = (result.beat.offset == '0);

   // A result is only produced by a step that had room in the result register.
   `JEMSL_ASSERT_SAME(a_push_has_room, clock, reset, result.valid, step_room, "no room")

   // An end-of-stream beat always leaves the parser expecting a marker prefix.
   `JEMSL_ASSERT_NEXT(a_end_clears, clock, reset, end_step, prefix_phase, "parser not cleared")

   // Failure and not-found results carry a zero offset.
   `JEMSL_ASSERT_SAME(a_fail_zero_off, clock, reset, zero_kind_push, zero_off, "nonzero offset")

endmodule
